@@ sv/lpht_pkg.sv @@
// types, constants and the hash function shared by the hash table core
`default_nettype none
package lpht_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int KEY_W         = 64;
  localparam int REC_W         = 20;
  localparam int CFG_W         = 11;
  localparam int SLOT_W        = 10;
  localparam int COLL_W        = 10;
  localparam int HSUM_W        = 14;
  localparam int HCNT_W        = $clog2(HSUM_W);
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 11'd1021;
  localparam logic [CFG_W-1:0]  TABLE_SIZE_MIN = 11'd2;
  localparam logic [REC_W-1:0]  REC_STEP       = 20'd192;
  localparam logic [REC_W-1:0]  REC_MAX        = 20'hFFFFF;
  localparam logic [COLL_W-1:0] COLL_MAX       = 10'd1023;

  // register index is paddr[2]
  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_SEARCH  = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_INSPECT = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_FULL      = 3'd2,
    STS_FOUND     = 3'd3,
    STS_NOT_FOUND = 3'd4,
    STS_REMOVED   = 3'd5,
    STS_SLOT_READ = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    SLOT_FREE = 2'd0,
    SLOT_OCC  = 2'd1,
    SLOT_REM  = 2'd2
  } slot_state_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    logic [SLOT_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [COLL_W-1:0] collisions;
    logic [SLOT_W-1:0] slot;
    logic [REC_W-1:0]  record_offset;
    logic [1:0]        slot_state;
    logic [KEY_W-1:0]  slot_key;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       state;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] record;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // weighted byte sum, first character weighted by one
  function automatic logic [HSUM_W-1:0] hash_sum(logic [KEY_W-1:0] key);
    logic [HSUM_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + HSUM_W'(key[KEY_W-1-8*i -: 8]) * HSUM_W'(i + 1);
    end
    return sum;
  endfunction

endpackage
`default_nettype wire

@@ sv/lpht_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/linear_probe_hash_table_core.sv @@
// linear probing hash table of 8-byte keys with removed-slot markers
//
// After reset the core clears the slot store, one slot a cycle, with busy
// high; the table_size register can be written meanwhile. Slot state, key
// and record offset live in one ram with a registered read, and every action
// reads it through that single read port. Insert computes the home slot with
// a bit-serial remainder, then scans the slots in use in index order to look
// for a duplicate and the first free or removed slot in probe order, stopping
// early at a duplicate. Search and remove stop at the first matching slot, or
// scan every slot in use when the key is absent; inspect reads the one slot
// that it names. Each result shows on result_o for a single cycle, marked by
// result_valid_o, in the cycle in which busy drops; the receiver cannot stall
// it, and a new item may be started in that same cycle.
`default_nettype none
module linear_probe_hash_table_core #(
  parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire lpht_pkg::in_item_t        item_i,
  output lpht_pkg::out_item_t            result_o,
  output logic                           result_valid_o,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [lpht_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lpht_pkg::DATA_W-1:0] pwdata,
  output logic      [lpht_pkg::DATA_W-1:0] prdata,
  output logic                           pready
);
  import lpht_pkg::*;

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = (AW > CFG_W) ? AW : CFG_W;
  localparam int IW = (AW > SLOT_W) ? AW : SLOT_W;

  fsm_e              state_q, state_d;
  in_item_t          item_q, item_d;
  logic [CFG_W-1:0]  table_size_q, table_size_d;
  logic [CFG_W-1:0]  size_q, size_d, size_eff;
  logic [HSUM_W-1:0] div_q, div_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [HCNT_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     iss_q, iss_d;
  logic              iss_done_q, iss_done_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic              found_q, found_d;
  logic [AW-1:0]     found_idx_q, found_idx_d;
  logic [REC_W-1:0]  found_rec_q, found_rec_d;
  logic              hi_q, hi_d;
  logic [AW-1:0]     hi_idx_q, hi_idx_d;
  logic              lo_q, lo_d;
  logic [AW-1:0]     lo_idx_q, lo_idx_d;
  logic [REC_W-1:0]  next_rec_q, next_rec_d;
  out_item_t         res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr;
  entry_t            mem_rdata;

  logic [CFG_W:0]    rem_try;
  logic [CFG_W:0]    rem_sub;
  logic [CW-1:0]     size_m1;
  logic              rd_match;
  logic              rd_free;
  logic [CW:0]       coll_raw;
  logic [AW-1:0]     ins_pos;
  logic [IW-1:0]     sidx_ext;
  logic              insp_oob;
  logic              cfg_wr;

  lpht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);
  assign table_size_d = cfg_wr ? pwdata[CFG_W-1:0] : table_size_q;
  assign prdata = (paddr[2] == REG_TABLE_SIZE) ? DATA_W'(table_size_q) : '0;

  always_comb begin
    if (table_size_q < TABLE_SIZE_MIN) begin
      size_eff = TABLE_SIZE_MIN;
    end else if (32'(table_size_q) > 32'(MAX_SLOTS)) begin
      size_eff = CFG_W'(MAX_SLOTS);
    end else begin
      size_eff = table_size_q;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_o       = res_q;
  assign result_valid_o = res_vld_q;

  assign rem_try  = {rem_q, div_q[HSUM_W-1]};
  assign rem_sub  = rem_try - {1'b0, size_q};
  assign size_m1  = CW'(size_q) - CW'(1);
  assign rd_match = (mem_rdata.state == SLOT_OCC) && (mem_rdata.key == item_q.key);
  assign rd_free  = (mem_rdata.state != SLOT_OCC);
  assign ins_pos  = hi_q ? hi_idx_q : lo_idx_q;
  assign coll_raw = hi_q ? ((CW+1)'(hi_idx_q) - (CW+1)'(rem_q))
                         : ((CW+1)'(lo_idx_q) + (CW+1)'(size_q) - (CW+1)'(rem_q));
  assign sidx_ext = IW'(item_q.slot_index);
  assign insp_oob = 32'(item_q.slot_index) >= 32'(MAX_SLOTS);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    size_d      = size_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    iss_d       = iss_q;
    iss_done_d  = iss_done_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = iss_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_rec_d = found_rec_q;
    hi_d        = hi_q;
    hi_idx_d    = hi_idx_q;
    lo_d        = lo_q;
    lo_idx_d    = lo_idx_q;
    next_rec_d  = next_rec_q;
    res_d       = res_q;
    res_vld_d   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;
    mem_raddr   = iss_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_q;
        mem_wdata       = '0;
        mem_wdata.state = SLOT_FREE;
        if (clr_q == AW'(MAX_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          item_d     = item_i;
          size_d     = size_eff;
          div_d      = hash_sum(item_i.key);
          rem_d      = '0;
          cnt_d      = '0;
          iss_d      = '0;
          iss_done_d = 1'b0;
          found_d    = 1'b0;
          hi_d       = 1'b0;
          lo_d       = 1'b0;
          unique case (action_e'(item_i.action))
            ACT_INSERT:             state_d = ST_HASH;
            ACT_SEARCH, ACT_REMOVE: state_d = ST_SCAN;
            ACT_INSPECT:            state_d = ST_READ;
            default:                state_d = ST_READ;
          endcase
        end
      end

      // one remainder bit a cycle
      ST_HASH: begin
        rem_d = (rem_try >= {1'b0, size_q}) ? rem_sub[CFG_W-1:0] : rem_try[CFG_W-1:0];
        div_d = div_q << 1;
        if (cnt_q == HCNT_W'(HSUM_W - 1)) begin
          state_d = ST_SCAN;
        end else begin
          cnt_d = cnt_q + HCNT_W'(1);
        end
      end

      ST_SCAN: begin
        if (!iss_done_q) begin
          mem_raddr = iss_q;
          rd_vld_d  = 1'b1;
          rd_idx_d  = iss_q;
          if (CW'(iss_q) == size_m1) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + AW'(1);
          end
        end
        if (rd_vld_q) begin
          if (rd_free && !hi_q && (CW'(rd_idx_q) >= CW'(rem_q))) begin
            hi_d     = 1'b1;
            hi_idx_d = rd_idx_q;
          end
          if (rd_free && !lo_q) begin
            lo_d     = 1'b1;
            lo_idx_d = rd_idx_q;
          end
          if (rd_match) begin
            found_d     = 1'b1;
            found_idx_d = rd_idx_q;
            found_rec_d = mem_rdata.record;
          end
          if (rd_match || (CW'(rd_idx_q) == size_m1)) begin
            state_d = ST_DONE;
          end
        end
      end

      ST_READ: begin
        mem_raddr = sidx_ext[AW-1:0];
        state_d   = ST_DONE;
      end

      ST_DONE: begin
        state_d   = ST_IDLE;
        res_vld_d = 1'b1;
        res_d     = '0;
        case (action_e'(item_q.action))
          ACT_INSERT: begin
            if (found_q) begin
              res_d.status        = STS_DUPLICATE;
              res_d.slot          = SLOT_W'(found_idx_q);
              res_d.record_offset = found_rec_q;
              res_d.slot_state    = SLOT_OCC;
              res_d.slot_key      = item_q.key;
            end else if (hi_q || lo_q) begin
              mem_we           = 1'b1;
              mem_waddr        = ins_pos;
              mem_wdata.state  = SLOT_OCC;
              mem_wdata.key    = item_q.key;
              mem_wdata.record = next_rec_q;
              res_d.status        = STS_INSERTED;
              res_d.collisions    = (coll_raw > (CW+1)'(COLL_MAX)) ? COLL_MAX
                                                                   : coll_raw[COLL_W-1:0];
              res_d.slot          = SLOT_W'(ins_pos);
              res_d.record_offset = next_rec_q;
              res_d.slot_state    = SLOT_OCC;
              res_d.slot_key      = item_q.key;
              next_rec_d = (next_rec_q > REC_MAX - REC_STEP) ? REC_MAX
                                                             : next_rec_q + REC_STEP;
            end else begin
              res_d.status = STS_FULL;
            end
          end
          ACT_SEARCH, ACT_REMOVE: begin
            if (!found_q) begin
              res_d.status = STS_NOT_FOUND;
            end else begin
              res_d.slot          = SLOT_W'(found_idx_q);
              res_d.record_offset = found_rec_q;
              res_d.slot_key      = item_q.key;
              if (action_e'(item_q.action) == ACT_SEARCH) begin
                res_d.status     = STS_FOUND;
                res_d.slot_state = SLOT_OCC;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = found_idx_q;
                mem_wdata.state  = SLOT_REM;
                mem_wdata.key    = item_q.key;
                mem_wdata.record = found_rec_q;
                res_d.status     = STS_REMOVED;
                res_d.slot_state = SLOT_REM;
              end
            end
          end
          default: begin
            res_d.status = STS_SLOT_READ;
            res_d.slot   = item_q.slot_index;
            if (!insp_oob && (mem_rdata.state != SLOT_FREE)) begin
              res_d.record_offset = mem_rdata.record;
              res_d.slot_state    = mem_rdata.state;
              res_d.slot_key      = mem_rdata.key;
            end
          end
        endcase
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      table_size_q <= TABLE_SIZE_RST;
      clr_q        <= '0;
      cnt_q        <= '0;
      iss_q        <= '0;
      iss_done_q   <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      hi_q         <= 1'b0;
      lo_q         <= 1'b0;
      next_rec_q   <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      table_size_q <= table_size_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      iss_q        <= iss_d;
      iss_done_q   <= iss_done_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      hi_q         <= hi_d;
      lo_q         <= lo_d;
      next_rec_q   <= next_rec_d;
      res_vld_q    <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    size_q      <= size_d;
    div_q       <= div_d;
    rem_q       <= rem_d;
    rd_idx_q    <= rd_idx_d;
    found_idx_q <= found_idx_d;
    found_rec_q <= found_rec_d;
    hi_idx_q    <= hi_idx_d;
    lo_idx_q    <= lo_idx_d;
    res_q       <= res_d;
  end

endmodule
`default_nettype wire

@@ verif/linear_probe_hash_table_core_tb.sv @@
// self-checking testbench for the linear probing hash table core
module linear_probe_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  localparam int NSLOT = MAX_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam logic [ADDR_W-1:0] TABLE_SIZE_ADDR = {REG_TABLE_SIZE, 2'b00};

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_item_t          item_i;
  out_item_t         result_o;
  logic              result_valid_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  slot_state_e       tbl_state [NSLOT];
  logic [KEY_W-1:0]  tbl_key [NSLOT];
  logic [REC_W-1:0]  tbl_rec [NSLOT];
  logic [REC_W-1:0]  tbl_next_rec;
  logic [CFG_W-1:0]  tbl_size;

  out_item_t         table_results_q [$];
  out_item_t         want_item;
  int unsigned       err_count;
  int unsigned       result_count;
  int unsigned       cycle_count;

  linear_probe_hash_table_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_probe_hash_table_core: mismatch");
      $finish;
    end
  end

  function automatic int unsigned active_slots();
    if (tbl_size < 2) return 2;
    if (tbl_size > NSLOT) return NSLOT;
    return tbl_size;
  endfunction

  function automatic int unsigned home_of(logic [KEY_W-1:0] k, int unsigned n);
    int unsigned acc;
    acc = 0;
    for (int b = 0; b < 8; b++) begin
      acc += k[KEY_W-1-8*b -: 8] * (b + 1);
    end
    return acc % n;
  endfunction

  function automatic int unsigned find_key(logic [KEY_W-1:0] k, int unsigned n);
    for (int unsigned j = 0; j < n; j++) begin
      if (tbl_state[j] == SLOT_OCC && tbl_key[j] == k) return j;
    end
    return n;
  endfunction

  function automatic int unsigned first_open_slot(int unsigned n);
    for (int unsigned j = 0; j < n; j++) begin
      if (tbl_state[j] != SLOT_OCC) return j;
    end
    return n;
  endfunction

  function automatic out_item_t do_table_action(in_item_t it);
    out_item_t   r;
    int unsigned n;
    int unsigned j;
    int unsigned pos;
    int unsigned coll;
    bit          placed;
    r = '0;
    n = active_slots();
    case (action_e'(it.action))
      ACT_INSERT: begin
        j = find_key(it.key, n);
        if (j < n) begin
          r.status        = STS_DUPLICATE;
          r.slot          = SLOT_W'(j);
          r.record_offset = tbl_rec[j];
          r.slot_state    = SLOT_OCC;
          r.slot_key      = it.key;
        end else begin
          r.status = STS_FULL;
          pos      = home_of(it.key, n);
          coll     = 0;
          placed   = 1'b0;
          for (int unsigned p = 0; p < n && !placed; p++) begin
            if (tbl_state[pos] != SLOT_OCC) begin
              placed          = 1'b1;
              tbl_state[pos]  = SLOT_OCC;
              tbl_key[pos]    = it.key;
              tbl_rec[pos]    = tbl_next_rec;
              r.status        = STS_INSERTED;
              r.collisions    = (coll > COLL_MAX) ? COLL_MAX : COLL_W'(coll);
              r.slot          = SLOT_W'(pos);
              r.record_offset = tbl_next_rec;
              r.slot_state    = SLOT_OCC;
              r.slot_key      = it.key;
              tbl_next_rec    = (tbl_next_rec > REC_MAX - REC_STEP) ? REC_MAX
                                                                    : tbl_next_rec + REC_STEP;
            end else begin
              coll++;
              pos = (pos + 1 == n) ? 0 : pos + 1;
            end
          end
        end
      end
      ACT_SEARCH, ACT_REMOVE: begin
        j = find_key(it.key, n);
        if (j >= n) begin
          r.status = STS_NOT_FOUND;
        end else begin
          r.slot          = SLOT_W'(j);
          r.record_offset = tbl_rec[j];
          r.slot_key      = it.key;
          if (action_e'(it.action) == ACT_SEARCH) begin
            r.status     = STS_FOUND;
            r.slot_state = SLOT_OCC;
          end else begin
            tbl_state[j] = SLOT_REM;
            r.status     = STS_REMOVED;
            r.slot_state = SLOT_REM;
          end
        end
      end
      default: begin
        r.status = STS_SLOT_READ;
        r.slot   = it.slot_index;
        if (tbl_state[it.slot_index] != SLOT_FREE) begin
          r.record_offset = tbl_rec[it.slot_index];
          r.slot_state    = tbl_state[it.slot_index];
          r.slot_key      = tbl_key[it.slot_index];
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= 40) begin
      $display("result %0d: %s is 0x%0h, expected 0x%0h", result_count, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (table_results_q.size() == 0) begin
        report_mismatch("result with no item pending, status", result_o.status, '0);
      end else begin
        want_item = table_results_q.pop_front();
        if (result_o.status !== want_item.status)
          report_mismatch("status", result_o.status, want_item.status);
        if (result_o.collisions !== want_item.collisions)
          report_mismatch("collisions", result_o.collisions, want_item.collisions);
        if (result_o.slot !== want_item.slot)
          report_mismatch("slot", result_o.slot, want_item.slot);
        if (result_o.record_offset !== want_item.record_offset)
          report_mismatch("record_offset", result_o.record_offset, want_item.record_offset);
        if (result_o.slot_state !== want_item.slot_state)
          report_mismatch("slot_state", result_o.slot_state, want_item.slot_state);
        if (result_o.slot_key !== want_item.slot_key)
          report_mismatch("slot_key", result_o.slot_key, want_item.slot_key);
      end
    end
  end

  task automatic send_action(action_e act, logic [KEY_W-1:0] key, logic [SLOT_W-1:0] idx);
    in_item_t it;
    it.action     = act;
    it.key        = key;
    it.slot_index = idx;
    @(negedge clk_i);
    start  = 1'b1;
    item_i = it;
    do @(posedge clk_i); while (busy !== 1'b0);
    table_results_q.push_back(do_table_action(it));
  endtask

  task automatic pause_sender(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (table_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = TABLE_SIZE_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_table_size(logic [CFG_W-1:0] v);
    logic [DATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, DATA_W'(v), rd);
    tbl_size = v;
    apb_access(1'b0, '0, rd);
    if (rd !== DATA_W'(v)) report_mismatch("table_size readback", rd, v);
  endtask

  task automatic run_random_phase(logic [CFG_W-1:0] size, int unsigned count);
    logic [KEY_W-1:0]  pool [16];
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] idx;
    int unsigned       n;
    int unsigned       r;
    int unsigned       k;
    bit                burst;
    action_e           act;
    write_table_size(size);
    n = active_slots();
    for (int i = 0; i < 16; i++) begin
      pool[i] = {$urandom, $urandom};
      if ($urandom_range(1)) begin
        k = $urandom_range(n - 1);
        if (tbl_state[k] != SLOT_FREE) pool[i] = tbl_key[k];
      end
    end
    burst = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 32 == 0) burst = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 40) act = ACT_INSERT;
      else if (r < 65) act = ACT_SEARCH;
      else if (r < 85) act = ACT_REMOVE;
      else act = ACT_INSPECT;
      key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : pool[$urandom_range(15)];
      idx = SLOT_W'($urandom_range(NSLOT - 1));
      if (act == ACT_INSPECT && $urandom_range(3) != 0) idx = SLOT_W'($urandom_range(n - 1));
      send_action(act, key, idx);
      if ($urandom_range(99) == 0) wait_idle();
      else if (!burst) pause_sender(idle_len());
    end
  endtask

  task automatic test_directed_actions();
    send_action(ACT_INSPECT, '0, '0);
    send_action(ACT_SEARCH, '0, '0);
    send_action(ACT_REMOVE, '1, '0);
    send_action(ACT_INSERT, '0, '0);
    send_action(ACT_INSERT, '1, '1);
    send_action(ACT_INSERT, '0, '0);
    send_action(ACT_SEARCH, '1, '0);
    send_action(ACT_INSPECT, '0, 10'd1012);
    send_action(ACT_INSPECT, '1, '1);
    send_action(ACT_REMOVE, '0, '0);
    send_action(ACT_INSPECT, '0, '0);
    send_action(ACT_SEARCH, '0, '0);
    // four keys sharing home slot 0, one more than the table holds
    write_table_size(11'd3);
    send_action(ACT_INSERT, 64'h3, '0);
    send_action(ACT_INSERT, 64'h6, '0);
    send_action(ACT_INSERT, 64'h9, '0);
    send_action(ACT_INSERT, 64'hC, '0);
    send_action(ACT_REMOVE, 64'h6, '0);
    send_action(ACT_INSERT, 64'hC, '0);
    send_action(ACT_SEARCH, 64'hC, '0);
    send_action(ACT_INSPECT, '0, 10'd0);
    send_action(ACT_INSPECT, '0, 10'd1);
    send_action(ACT_INSPECT, '0, 10'd2);
    send_action(ACT_INSPECT, '0, 10'd1012);
  endtask

  task automatic test_record_offset_growth();
    logic [KEY_W-1:0] key;
    write_table_size(11'd2);
    if (first_open_slot(2) == 2) send_action(ACT_REMOVE, tbl_key[0], '0);
    key = {$urandom, $urandom};
    repeat (75) begin
      send_action(ACT_INSERT, key, SLOT_W'($urandom_range(NSLOT - 1)));
      send_action(ACT_REMOVE, key, SLOT_W'($urandom_range(NSLOT - 1)));
      if ($urandom_range(15) == 0) pause_sender(idle_len());
    end
  endtask

  task automatic test_random_small_tables();
    logic [CFG_W-1:0] sizes [10] = '{11'd2, 11'd0, 11'd3, 11'd1, 11'd5,
                                     11'd7, 11'd13, 11'd31, 11'd61, 11'd127};
    foreach (sizes[i]) run_random_phase(sizes[i], 45);
  endtask

  // grow the table one slot at a time so the last insert walks past every slot
  task automatic test_probe_chain_fill();
    logic [KEY_W-1:0] key;
    for (int s = 2; s <= NSLOT; s++) begin
      write_table_size(CFG_W'(s));
      while (first_open_slot(s) < s) begin
        do key = {$urandom, $urandom}; while (s == NSLOT && home_of(key, NSLOT) != 0);
        send_action(ACT_INSERT, key, SLOT_W'($urandom_range(NSLOT - 1)));
      end
    end
    send_action(ACT_INSERT, {$urandom, $urandom}, '0);
    send_action(ACT_SEARCH, tbl_key[NSLOT-1], '0);
  endtask

  task automatic test_random_large_tables();
    run_random_phase(11'd1024, 15);
    run_random_phase(11'd2047, 15);
    run_random_phase(11'd1021, 15);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    item_i  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    err_count    = 0;
    result_count = 0;
    cycle_count  = 0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_state[i] = SLOT_FREE;
      tbl_key[i]   = '0;
      tbl_rec[i]   = '0;
    end
    tbl_next_rec = '0;
    tbl_size     = TABLE_SIZE_RST;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_actions();
    test_record_offset_growth();
    test_random_small_tables();
    test_probe_chain_fill();
    test_random_large_tables();

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("linear_probe_hash_table_core: match");
    end else begin
      $display("linear_probe_hash_table_core: mismatch");
    end
    $finish;
  end

endmodule
